>>> sv/apsa_pkg.sv
// Shared widths, codes, types and helpers of the affine pixel scramble address block.
package apsa_pkg;

	localparam int MAX_DIM = 4096;

	localparam int DIM_W = 13;
	localparam int CNT_W = 12;
	localparam int COEF_W = 12;
	localparam int ACC_W = 25;
	localparam int IDX_W = 24;
	localparam int PIX_W = 8;
	localparam int MUL_STEPS = COEF_W;
	localparam int STEP_W = 5;

	localparam int APB_DW = 32;
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_WIDTH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_XX = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_XY = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_YX = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COEF_YY = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 3'd7;

	localparam logic [1:0] OP_MAC = 2'd0;
	localparam logic [1:0] OP_MOD = 2'd1;
	localparam logic [1:0] OP_MODC = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [COEF_W-1:0] coef_xx;
		logic [COEF_W-1:0] coef_xy;
		logic [COEF_W-1:0] coef_yx;
		logic [COEF_W-1:0] coef_yy;
		logic [COEF_W-1:0] shift_x;
		logic [COEF_W-1:0] shift_y;
	} apsa_cfg_t;

	typedef struct packed {
		logic start;
		logic [1:0] op;
		logic [DIM_W-1:0] a1;
		logic [COEF_W-1:0] b1;
		logic [DIM_W-1:0] a2;
		logic [COEF_W-1:0] b2;
		logic [ACC_W-1:0] c;
		logic [DIM_W-1:0] m;
	} apsa_lane_cmd_t;

	typedef struct packed {
		logic busy;
		logic [ACC_W-1:0] result;
	} apsa_lane_sts_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> sv/apsa_pix_if.sv
// Input pixel channel: valid, ready, direction and the three color bytes.
interface apsa_pix_if import apsa_pkg::*; ();
	logic valid;
	logic ready;
	logic cmd;
	logic [PIX_W-1:0] red_value;
	logic [PIX_W-1:0] green_value;
	logic [PIX_W-1:0] blue_value;

	modport source (output valid, output cmd, output red_value, output green_value,
		output blue_value, input ready);
	modport sink (input valid, input cmd, input red_value, input green_value,
		input blue_value, output ready);
endinterface

>>> sv/apsa_res_if.sv
// Result channel: valid, ready, destination index, color bytes and flags.
interface apsa_res_if import apsa_pkg::*; ();
	logic valid;
	logic ready;
	logic [IDX_W-1:0] dest_index;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic not_invertible;
	logic frame_end;

	modport source (output valid, output dest_index, output red_out, output green_out,
		output blue_out, output not_invertible, output frame_end, input ready);
	modport sink (input valid, input dest_index, input red_out, input green_out,
		input blue_out, input not_invertible, input frame_end, output ready);
endinterface

>>> sv/apsa_regs.sv
// APB register file holding frame size, matrix coefficients and offsets.
module apsa_regs import apsa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic pready,
	output apsa_cfg_t cfg,
	output logic cfg_wr
);

	logic [REG_IDX_W-1:0] idx;
	apsa_cfg_t cfg_q;

	assign pready = 1'b1;
	assign idx = paddr[ADDR_W-1:2];
	assign cfg_wr = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= DIM_W'(256);
			cfg_q.height <= DIM_W'(256);
			cfg_q.coef_xx <= COEF_W'(1);
			cfg_q.coef_xy <= '0;
			cfg_q.coef_yx <= '0;
			cfg_q.coef_yy <= COEF_W'(1);
			cfg_q.shift_x <= '0;
			cfg_q.shift_y <= '0;
		end else if (cfg_wr) begin
			case (idx)
				REG_WIDTH: cfg_q.width <= pwdata[DIM_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[DIM_W-1:0];
				REG_COEF_XX: cfg_q.coef_xx <= pwdata[COEF_W-1:0];
				REG_COEF_XY: cfg_q.coef_xy <= pwdata[COEF_W-1:0];
				REG_COEF_YX: cfg_q.coef_yx <= pwdata[COEF_W-1:0];
				REG_COEF_YY: cfg_q.coef_yy <= pwdata[COEF_W-1:0];
				REG_SHIFT_X: cfg_q.shift_x <= pwdata[COEF_W-1:0];
				REG_SHIFT_Y: cfg_q.shift_y <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH: prdata = APB_DW'(cfg_q.width);
			REG_HEIGHT: prdata = APB_DW'(cfg_q.height);
			REG_COEF_XX: prdata = APB_DW'(cfg_q.coef_xx);
			REG_COEF_XY: prdata = APB_DW'(cfg_q.coef_xy);
			REG_COEF_YX: prdata = APB_DW'(cfg_q.coef_yx);
			REG_COEF_YY: prdata = APB_DW'(cfg_q.coef_yy);
			REG_SHIFT_X: prdata = APB_DW'(cfg_q.shift_x);
			REG_SHIFT_Y: prdata = APB_DW'(cfg_q.shift_y);
			default: prdata = '0;
		endcase
	end

endmodule

>>> sv/apsa_lane.sv
// Bit-serial arithmetic lane: shift-add multiply-accumulate and restoring remainder.
module apsa_lane import apsa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input apsa_lane_cmd_t cmd,
	output apsa_lane_sts_t sts
);

	logic busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic is_mac_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] ma1_q;
	logic [ACC_W-1:0] ma2_q;
	logic [ACC_W-1:0] dv_q;
	logic [COEF_W-1:0] mb1_q;
	logic [COEF_W-1:0] mb2_q;
	logic [CNT_W-1:0] rem_q;
	logic [DIM_W-1:0] m_q;
	logic [DIM_W-1:0] trial;
	logic [DIM_W-1:0] rem_next;
	logic [ACC_W-1:0] acc_next;

	always_comb begin
		trial = {rem_q, dv_q[ACC_W-1]};
		rem_next = (trial >= m_q) ? trial - m_q : trial;
		acc_next = acc_q + (mb1_q[0] ? ma1_q : '0) + (mb2_q[0] ? ma2_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			case (cmd.op)
				OP_MAC: cnt_q <= STEP_W'(MUL_STEPS);
				OP_MOD: cnt_q <= STEP_W'(ACC_W);
				OP_MODC: cnt_q <= STEP_W'(CNT_W);
				default: begin
					busy_q <= 1'b0;
					cnt_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			m_q <= cmd.m;
			rem_q <= '0;
			case (cmd.op)
				OP_MAC: begin
					is_mac_q <= 1'b1;
					acc_q <= cmd.c;
					ma1_q <= ACC_W'(cmd.a1);
					ma2_q <= ACC_W'(cmd.a2);
					mb1_q <= cmd.b1;
					mb2_q <= cmd.b2;
				end
				OP_MOD: begin
					is_mac_q <= 1'b0;
					dv_q <= acc_q;
				end
				OP_MODC: begin
					is_mac_q <= 1'b0;
					dv_q <= {cmd.c[CNT_W-1:0], {(ACC_W-CNT_W){1'b0}}};
				end
				default: is_mac_q <= 1'b0;
			endcase
		end else if (busy_q) begin
			if (is_mac_q) begin
				acc_q <= acc_next;
				ma1_q <= ma1_q << 1;
				ma2_q <= ma2_q << 1;
				mb1_q <= mb1_q >> 1;
				mb2_q <= mb2_q >> 1;
			end else begin
				rem_q <= rem_next[CNT_W-1:0];
				dv_q <= dv_q << 1;
				if (cnt_q == STEP_W'(1)) begin
					acc_q <= ACC_W'(rem_next);
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.result = acc_q;

endmodule

>>> sv/affine_pixel_scramble_address_top.sv
// Top level: pixel sequencer, raster counters, inverse search and result register.
// Pixels are taken one at a time in raster order. Arithmetic runs on two bit-serial
// lanes, x modulo the width and y modulo the height (y modulo the width while the
// inverse matrix is built; the index step uses the x lane only). A multiply-accumulate
// or a 12-bit position reduction runs 12 bit steps, a 25-bit remainder one per bit.
// A forward pixel runs position reduction, multiply-accumulate, remainder and index;
// an inverse pixel adds a shift reduction. The first inverse pixel after reset or
// after any register write also computes the inverse matrix, searching one cycle per
// candidate over up to width minus one candidates. The next pixel is accepted once the
// sequencer is idle; the previous result may still wait in the output register.
module affine_pixel_scramble_address_top import apsa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic pready,
	apsa_pix_if.sink pix,
	apsa_res_if.source res
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_POS = 4'd1;
	localparam logic [3:0] ST_FMAC = 4'd2;
	localparam logic [3:0] ST_FMOD = 4'd3;
	localparam logic [3:0] ST_IDX = 4'd4;
	localparam logic [3:0] ST_OUT = 4'd5;
	localparam logic [3:0] ST_DMAC = 4'd6;
	localparam logic [3:0] ST_DMOD = 4'd7;
	localparam logic [3:0] ST_SRCH = 4'd8;
	localparam logic [3:0] ST_C1MAC = 4'd9;
	localparam logic [3:0] ST_C1MOD = 4'd10;
	localparam logic [3:0] ST_C2MAC = 4'd11;
	localparam logic [3:0] ST_C2MOD = 4'd12;
	localparam logic [3:0] ST_SHF = 4'd13;
	localparam logic [3:0] ST_IMAC = 4'd14;

	apsa_cfg_t cfg;
	logic cfg_wr;
	apsa_lane_cmd_t cmd_x;
	apsa_lane_cmd_t cmd_y;
	apsa_lane_sts_t sts_x;
	apsa_lane_sts_t sts_y;

	logic [3:0] state_q;
	logic issued_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic inv_ready_q;
	logic inv_failed_q;
	logic res_valid_q;

	logic cmd_q;
	logic [PIX_W-1:0] red_q;
	logic [PIX_W-1:0] green_q;
	logic [PIX_W-1:0] blue_q;
	logic fe_q;
	logic bad_q;
	logic [CNT_W-1:0] x_q;
	logic [CNT_W-1:0] y_q;
	logic [CNT_W-1:0] nx_q;
	logic [CNT_W-1:0] ny_q;
	logic [IDX_W-1:0] dest_q;
	logic [CNT_W-1:0] det_q;
	logic [CNT_W-1:0] r_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] inv_q [4];

	logic [IDX_W-1:0] dest_o_q;
	logic [PIX_W-1:0] red_o_q;
	logic [PIX_W-1:0] green_o_q;
	logic [PIX_W-1:0] blue_o_q;
	logic ni_o_q;
	logic fe_o_q;

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic last_col;
	logic last_row;
	logic use_x;
	logic use_y;
	logic lanes_idle;
	logic op_done;
	logic accept;
	logic out_load;
	logic [CNT_W-1:0] rx;
	logic [CNT_W-1:0] ry;
	logic [DIM_W-1:0] r_sum;
	logic [DIM_W-1:0] r_wrap;
	logic [DIM_W-1:0] i_next;
	logic found;
	logic exhausted;

	function automatic logic [CNT_W-1:0] mod_sub(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b, input logic [DIM_W-1:0] m);
		logic [DIM_W-1:0] t;
		if (a >= b) begin
			t = DIM_W'(a) - DIM_W'(b);
		end else begin
			t = DIM_W'(a) + m - DIM_W'(b);
		end
		return t[CNT_W-1:0];
	endfunction

	apsa_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg),
		.cfg_wr(cfg_wr)
	);

	apsa_lane u_lane_x (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_x),
		.sts(sts_x)
	);

	apsa_lane u_lane_y (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_y),
		.sts(sts_y)
	);

	assign w_eff = eff_dim(cfg.width);
	assign h_eff = eff_dim(cfg.height);
	assign last_col = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
	assign last_row = (DIM_W'(row_q) + DIM_W'(1)) >= h_eff;
	assign lanes_idle = !sts_x.busy && !sts_y.busy;
	assign op_done = issued_q && lanes_idle;
	assign accept = pix.valid && pix.ready;
	assign out_load = (state_q == ST_OUT) && (!res_valid_q || res.ready);
	assign rx = sts_x.result[CNT_W-1:0];
	assign ry = sts_y.result[CNT_W-1:0];
	assign r_sum = DIM_W'(r_q) + DIM_W'(det_q);
	assign r_wrap = (r_sum >= w_eff) ? r_sum - w_eff : r_sum;
	assign i_next = DIM_W'(i_q) + DIM_W'(1);
	assign found = (r_q == CNT_W'(1));
	assign exhausted = i_next >= w_eff;

	assign pix.ready = (state_q == ST_IDLE);
	assign res.valid = res_valid_q;
	assign res.dest_index = dest_o_q;
	assign res.red_out = red_o_q;
	assign res.green_out = green_o_q;
	assign res.blue_out = blue_o_q;
	assign res.not_invertible = ni_o_q;
	assign res.frame_end = fe_o_q;

	always_comb begin
		cmd_x = '0;
		cmd_y = '0;
		use_x = 1'b0;
		use_y = 1'b0;
		case (state_q)
			ST_POS: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MODC;
				cmd_x.c = ACC_W'(x_q);
				cmd_x.m = w_eff;
				cmd_y.op = OP_MODC;
				cmd_y.c = ACC_W'(y_q);
				cmd_y.m = h_eff;
			end
			ST_SHF: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MODC;
				cmd_x.c = ACC_W'(cfg.shift_x);
				cmd_x.m = w_eff;
				cmd_y.op = OP_MODC;
				cmd_y.c = ACC_W'(cfg.shift_y);
				cmd_y.m = h_eff;
			end
			ST_FMAC: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MAC;
				cmd_x.a1 = DIM_W'(cfg.coef_xx);
				cmd_x.b1 = x_q;
				cmd_x.a2 = DIM_W'(cfg.coef_xy);
				cmd_x.b2 = y_q;
				cmd_x.c = ACC_W'(cfg.shift_x);
				cmd_y.op = OP_MAC;
				cmd_y.a1 = DIM_W'(cfg.coef_yx);
				cmd_y.b1 = x_q;
				cmd_y.a2 = DIM_W'(cfg.coef_yy);
				cmd_y.b2 = y_q;
				cmd_y.c = ACC_W'(cfg.shift_y);
			end
			ST_IMAC: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MAC;
				cmd_x.a1 = DIM_W'(inv_q[0]);
				cmd_x.b1 = x_q;
				cmd_x.a2 = DIM_W'(inv_q[1]);
				cmd_x.b2 = y_q;
				cmd_y.op = OP_MAC;
				cmd_y.a1 = DIM_W'(inv_q[2]);
				cmd_y.b1 = x_q;
				cmd_y.a2 = DIM_W'(inv_q[3]);
				cmd_y.b2 = y_q;
			end
			ST_FMOD: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MOD;
				cmd_x.m = w_eff;
				cmd_y.op = OP_MOD;
				cmd_y.m = h_eff;
			end
			ST_IDX: begin
				use_x = 1'b1;
				cmd_x.op = OP_MAC;
				cmd_x.a1 = w_eff;
				cmd_x.b1 = ny_q;
				cmd_x.c = ACC_W'(nx_q);
				cmd_x.m = w_eff;
			end
			ST_DMAC: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MAC;
				cmd_x.a1 = DIM_W'(cfg.coef_xx);
				cmd_x.b1 = cfg.coef_yy;
				cmd_y.op = OP_MAC;
				cmd_y.a1 = DIM_W'(cfg.coef_xy);
				cmd_y.b1 = cfg.coef_yx;
			end
			ST_C1MAC: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MAC;
				cmd_x.a1 = DIM_W'(cfg.coef_yy);
				cmd_x.b1 = i_q;
				cmd_y.op = OP_MAC;
				cmd_y.a1 = DIM_W'(cfg.coef_xy);
				cmd_y.b1 = i_q;
			end
			ST_C2MAC: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MAC;
				cmd_x.a1 = DIM_W'(cfg.coef_xx);
				cmd_x.b1 = i_q;
				cmd_y.op = OP_MAC;
				cmd_y.a1 = DIM_W'(cfg.coef_yx);
				cmd_y.b1 = i_q;
			end
			ST_DMOD, ST_C1MOD, ST_C2MOD: begin
				use_x = 1'b1;
				use_y = 1'b1;
				cmd_x.op = OP_MOD;
				cmd_x.m = w_eff;
				cmd_y.op = OP_MOD;
				cmd_y.m = w_eff;
			end
			default: ;
		endcase
		cmd_x.start = use_x && !issued_q;
		cmd_y.start = use_y && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			inv_ready_q <= 1'b0;
			inv_failed_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				inv_ready_q <= 1'b0;
			end
			if (use_x || use_y) begin
				if (!issued_q) begin
					issued_q <= 1'b1;
				end else if (lanes_idle) begin
					issued_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last_col) begin
							col_q <= '0;
							row_q <= last_row ? '0 : row_q + CNT_W'(1);
						end else begin
							col_q <= col_q + CNT_W'(1);
						end
						if (!pix.cmd) begin
							state_q <= ST_POS;
						end else if (!inv_ready_q) begin
							state_q <= ST_DMAC;
						end else if (inv_failed_q) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_POS;
						end
					end
				end
				ST_POS: if (op_done) state_q <= cmd_q ? ST_SHF : ST_FMAC;
				ST_SHF: if (op_done) state_q <= ST_IMAC;
				ST_FMAC: if (op_done) state_q <= ST_FMOD;
				ST_IMAC: if (op_done) state_q <= ST_FMOD;
				ST_FMOD: if (op_done) state_q <= ST_IDX;
				ST_IDX: if (op_done) state_q <= ST_OUT;
				ST_DMAC: if (op_done) state_q <= ST_DMOD;
				ST_DMOD: if (op_done) state_q <= ST_SRCH;
				ST_SRCH: begin
					if (found) begin
						state_q <= ST_C1MAC;
					end else if (exhausted) begin
						inv_ready_q <= 1'b1;
						inv_failed_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_C1MAC: if (op_done) state_q <= ST_C1MOD;
				ST_C1MOD: if (op_done) state_q <= ST_C2MAC;
				ST_C2MAC: if (op_done) state_q <= ST_C2MOD;
				ST_C2MOD: begin
					if (op_done) begin
						inv_ready_q <= 1'b1;
						inv_failed_q <= 1'b0;
						state_q <= ST_POS;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= pix.cmd;
					red_q <= pix.red_value;
					green_q <= pix.green_value;
					blue_q <= pix.blue_value;
					fe_q <= last_col && last_row;
					x_q <= col_q;
					y_q <= row_q;
					bad_q <= pix.cmd && inv_ready_q && inv_failed_q;
					dest_q <= '0;
				end
			end
			ST_POS: begin
				if (op_done) begin
					x_q <= rx;
					y_q <= ry;
				end
			end
			ST_SHF: begin
				if (op_done) begin
					x_q <= mod_sub(x_q, rx, w_eff);
					y_q <= mod_sub(y_q, ry, h_eff);
				end
			end
			ST_FMOD: begin
				if (op_done) begin
					nx_q <= rx;
					ny_q <= ry;
				end
			end
			ST_IDX: begin
				if (op_done) begin
					dest_q <= sts_x.result[IDX_W-1:0];
				end
			end
			ST_DMOD: begin
				if (op_done) begin
					det_q <= mod_sub(rx, ry, w_eff);
					r_q <= mod_sub(rx, ry, w_eff);
					i_q <= CNT_W'(1);
				end
			end
			ST_SRCH: begin
				if (!found) begin
					if (exhausted) begin
						bad_q <= 1'b1;
						dest_q <= '0;
					end else begin
						i_q <= i_next[CNT_W-1:0];
						r_q <= r_wrap[CNT_W-1:0];
					end
				end
			end
			ST_C1MOD: begin
				if (op_done) begin
					inv_q[0] <= rx;
					inv_q[1] <= mod_sub('0, ry, w_eff);
				end
			end
			ST_C2MOD: begin
				if (op_done) begin
					inv_q[3] <= rx;
					inv_q[2] <= mod_sub('0, ry, w_eff);
				end
			end
			ST_OUT: begin
				if (out_load) begin
					dest_o_q <= dest_q;
					red_o_q <= red_q;
					green_o_q <= green_q;
					blue_o_q <= blue_q;
					ni_o_q <= bad_q;
					fe_o_q <= fe_q;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> sv/apsa_checker.sv
// Port-level assertions for the affine pixel scramble address block, with its bind.
module apsa_checker import apsa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [IDX_W-1:0] dest_index,
	input logic [PIX_W-1:0] red_out,
	input logic [PIX_W-1:0] green_out,
	input logic [PIX_W-1:0] blue_out,
	input logic not_invertible,
	input logic frame_end
);

	// A stalled result keeps its whole payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dest_index) && $stable(red_out)
		&& $stable(green_out) && $stable(blue_out) && $stable(not_invertible)
		&& $stable(frame_end))
		else $error("stalled result changed");

	// A pixel without an inverse always goes to index zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_invertible |-> dest_index == '0)
		else $error("non-invertible result with nonzero index");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in progress");

	// No result can appear in the cycle right after an item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind affine_pixel_scramble_address_top apsa_checker u_apsa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pix.valid),
	.in_ready(pix.ready),
	.out_valid(res.valid),
	.out_ready(res.ready),
	.dest_index(res.dest_index),
	.red_out(res.red_out),
	.green_out(res.green_out),
	.blue_out(res.blue_out),
	.not_invertible(res.not_invertible),
	.frame_end(res.frame_end)
);

>>> dv/tb_affine_pixel_scramble_address_top.sv
// Self-checking testbench for the affine pixel scramble address block: directed plan, then random phases.
module tb_affine_pixel_scramble_address_top;
	import apsa_pkg::*;

	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_INV = 1'b1;
	localparam int RANDOM_PIXELS = 1850;
	localparam int DRAIN_CYCLES = 200;

	typedef enum logic [1:0] {ROW_REG, ROW_PIX, ROW_PIX_KNOWN} row_kind_e;

	typedef struct packed {
		row_kind_e kind;
		logic [REG_IDX_W-1:0] reg_sel;
		logic [APB_DW-1:0] reg_val;
		logic cmd;
		logic [3*PIX_W-1:0] rgb;
		logic [IDX_W-1:0] exp_index;
		logic exp_bad;
		logic exp_last;
	} plan_row_t;

	typedef struct packed {
		logic [IDX_W-1:0] dest_index;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic not_invertible;
		logic frame_end;
	} placement_t;

	localparam int N_PLAN = 45;
	localparam plan_row_t PLAN [N_PLAN] = '{
		'{ROW_PIX_KNOWN, REG_WIDTH, 32'd0, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX_KNOWN, REG_WIDTH, 32'd0, DIR_FWD, 24'hFFFFFF, 24'd1, 1'b0, 1'b0},
		'{ROW_PIX_KNOWN, REG_WIDTH, 32'd0, DIR_INV, 24'hA55A3C, 24'd2, 1'b0, 1'b0},
		'{ROW_PIX_KNOWN, REG_WIDTH, 32'd0, DIR_INV, 24'h123456, 24'd3, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_XX, 32'd0, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX_KNOWN, REG_WIDTH, 32'd0, DIR_INV, 24'hFF00FF, 24'd0, 1'b1, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_FWD, 24'h00FF00, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_WIDTH, 32'd0, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_HEIGHT, 32'd0, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX_KNOWN, REG_WIDTH, 32'd0, DIR_INV, 24'h0F0F0F, 24'd0, 1'b1, 1'b1},
		'{ROW_PIX_KNOWN, REG_WIDTH, 32'd0, DIR_FWD, 24'hF0F0F0, 24'd0, 1'b0, 1'b1},
		'{ROW_REG, REG_WIDTH, 32'hFFFF_FFFF, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_HEIGHT, 32'd5000, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_XX, 32'd4095, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_XY, 32'hFFFF_FFFF, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_YX, 32'd0, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_YY, 32'd4095, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_SHIFT_X, 32'hFFFF_FFFF, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_SHIFT_Y, 32'd4095, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_FWD, 24'hFFFFFF, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'h808080, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_FWD, 24'h7F7F7F, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_XX, 32'd3, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_XY, 32'd0, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_YY, 32'd1, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'h010203, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_FWD, 24'h040506, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_WIDTH, 32'd6, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_HEIGHT, 32'd4, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_COEF_XX, 32'd2, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'hC3C3C3, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'h3C3C3C, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_WIDTH, 32'd5, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_HEIGHT, 32'd3, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_SHIFT_X, 32'd1, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_REG, REG_SHIFT_Y, 32'd2, DIR_FWD, 24'h000000, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_FWD, 24'h112233, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'h445566, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'h778899, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_FWD, 24'hAABBCC, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'hDDEEFF, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_FWD, 24'h55AA55, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_INV, 24'hAA55AA, 24'd0, 1'b0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 32'd0, DIR_FWD, 24'h0000FF, 24'd0, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	apsa_pix_if pix ();
	apsa_res_if res ();

	affine_pixel_scramble_address_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pix(pix),
		.res(res)
	);

	placement_t pending_results [$];
	int failures = 0;
	bit calm = 1'b0;

	apsa_cfg_t cfg_now;
	int unsigned col_pos;
	int unsigned row_pos;
	bit inv_known;
	bit inv_none;
	longint unsigned inv_m [4];

	function automatic longint unsigned modulus_of(logic [DIM_W-1:0] v);
		longint unsigned m;
		m = v;
		if (m == 0) begin
			m = 1;
		end
		if (m > MAX_DIM) begin
			m = MAX_DIM;
		end
		return m;
	endfunction

	function automatic void find_inverse(longint unsigned w);
		longint unsigned xx, xy, yx, yy, det, d, i;
		xx = cfg_now.coef_xx;
		xy = cfg_now.coef_xy;
		yx = cfg_now.coef_yx;
		yy = cfg_now.coef_yy;
		det = ((xx * yy) % w + w - (xy * yx) % w) % w;
		d = 0;
		inv_known = 1'b1;
		inv_none = 1'b1;
		if (det == 0) begin
			return;
		end
		for (i = 1; i < w; i++) begin
			if ((det * i) % w == 1) begin
				d = i;
				break;
			end
		end
		if (d == 0) begin
			return;
		end
		inv_none = 1'b0;
		inv_m[0] = (yy * d) % w;
		inv_m[1] = (w - (xy * d) % w) % w;
		inv_m[2] = (w - (yx * d) % w) % w;
		inv_m[3] = (xx * d) % w;
	endfunction

	function automatic placement_t place_pixel(logic cmd, logic [3*PIX_W-1:0] rgb);
		longint unsigned w, h, x, y, nx, ny, ax, ay, sx, sy, xx, xy, yx, yy;
		bit bad, last_col, last_row;
		placement_t p;
		w = modulus_of(cfg_now.width);
		h = modulus_of(cfg_now.height);
		x = col_pos % w;
		y = row_pos % h;
		sx = cfg_now.shift_x;
		sy = cfg_now.shift_y;
		xx = cfg_now.coef_xx;
		xy = cfg_now.coef_xy;
		yx = cfg_now.coef_yx;
		yy = cfg_now.coef_yy;
		nx = 0;
		ny = 0;
		bad = 1'b0;
		if (cmd == DIR_FWD) begin
			nx = (xx * x + xy * y + sx) % w;
			ny = (yx * x + yy * y + sy) % h;
		end else begin
			if (!inv_known) begin
				find_inverse(w);
			end
			if (inv_none) begin
				bad = 1'b1;
			end else begin
				ax = (x + w - sx % w) % w;
				ay = (y + h - sy % h) % h;
				nx = (inv_m[0] * ax + inv_m[1] * ay) % w;
				ny = (inv_m[2] * ax + inv_m[3] * ay) % h;
			end
		end
		last_col = (longint'(col_pos) + 1) >= w;
		last_row = (longint'(row_pos) + 1) >= h;
		p.dest_index = bad ? '0 : IDX_W'(nx + ny * w);
		p.red = rgb[3*PIX_W-1:2*PIX_W];
		p.green = rgb[2*PIX_W-1:PIX_W];
		p.blue = rgb[PIX_W-1:0];
		p.not_invertible = bad;
		p.frame_end = last_col && last_row;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
		return p;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 9);
		if (calm || r < 6) begin
			return 0;
		end
		if (r < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [APB_DW-1:0] with_junk(logic [APB_DW-1:0] val, int bits);
		logic [APB_DW-1:0] keep;
		keep = (APB_DW'(1) << bits) - 1;
		if ($urandom_range(0, 1) == 0) begin
			return val & keep;
		end
		return ($urandom & ~keep) | (val & keep);
	endfunction

	function automatic logic [APB_DW-1:0] rand_dim();
		case ($urandom_range(0, 15))
			0: return 0;
			1: return MAX_DIM;
			2: return $urandom_range(MAX_DIM + 1, 8191);
			3: return $urandom_range(25, MAX_DIM);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	function automatic logic [APB_DW-1:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 4095);
			1: return ($urandom_range(0, 1) == 0) ? 0 : 4095;
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] sel, logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			REG_WIDTH: cfg_now.width = val[DIM_W-1:0];
			REG_HEIGHT: cfg_now.height = val[DIM_W-1:0];
			REG_COEF_XX: cfg_now.coef_xx = val[COEF_W-1:0];
			REG_COEF_XY: cfg_now.coef_xy = val[COEF_W-1:0];
			REG_COEF_YX: cfg_now.coef_yx = val[COEF_W-1:0];
			REG_COEF_YY: cfg_now.coef_yy = val[COEF_W-1:0];
			REG_SHIFT_X: cfg_now.shift_x = val[COEF_W-1:0];
			default: cfg_now.shift_y = val[COEF_W-1:0];
		endcase
		inv_known = 1'b0;
		@(posedge clk);
	endtask

	task automatic maybe_write(logic [REG_IDX_W-1:0] sel, logic [APB_DW-1:0] val);
		if ($urandom_range(0, 3) != 0) begin
			write_reg(sel, val);
		end
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic send_pixel(logic cmd, logic [3*PIX_W-1:0] rgb, bit known, placement_t typed);
		placement_t p;
		int gap;
		pix.valid <= 1'b1;
		pix.cmd <= cmd;
		pix.red_value <= rgb[3*PIX_W-1:2*PIX_W];
		pix.green_value <= rgb[2*PIX_W-1:PIX_W];
		pix.blue_value <= rgb[PIX_W-1:0];
		do @(posedge clk); while (!pix.ready);
		p = place_pixel(cmd, rgb);
		pending_results.push_back(known ? typed : p);
		gap = idle_len();
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		placement_t want;
		int stall;
		stall = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with no pixel pending, expected none, got index %0d",
						$time, res.dest_index);
					failures++;
				end else begin
					want = pending_results.pop_front();
					check_field("dest_index", want.dest_index, res.dest_index);
					check_field("red_out", want.red, res.red_out);
					check_field("green_out", want.green, res.green_out);
					check_field("blue_out", want.blue, res.blue_out);
					check_field("not_invertible", want.not_invertible, res.not_invertible);
					check_field("frame_end", want.frame_end, res.frame_end);
				end
			end
			if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				stall = idle_len();
			end
		end
	end

	initial begin
		plan_row_t row;
		int sent;
		int batch;
		int inv_pct;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix.valid <= 1'b0;
		pix.cmd <= DIR_FWD;
		pix.red_value <= '0;
		pix.green_value <= '0;
		pix.blue_value <= '0;
		cfg_now = '{width: 13'd256, height: 13'd256, coef_xx: 12'd1, coef_xy: 12'd0,
			coef_yx: 12'd0, coef_yy: 12'd1, shift_x: 12'd0, shift_y: 12'd0};
		col_pos = 0;
		row_pos = 0;
		inv_known = 1'b0;
		inv_none = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_PLAN; k++) begin
			row = PLAN[k];
			case (row.kind)
				ROW_REG: begin
					pix.valid <= 1'b0;
					wait_drained();
					write_reg(row.reg_sel, row.reg_val);
				end
				ROW_PIX: send_pixel(row.cmd, row.rgb, 1'b0, '0);
				default: send_pixel(row.cmd, row.rgb, 1'b1, '{row.exp_index,
					row.rgb[3*PIX_W-1:2*PIX_W], row.rgb[2*PIX_W-1:PIX_W], row.rgb[PIX_W-1:0],
					row.exp_bad, row.exp_last});
			endcase
		end

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			pix.valid <= 1'b0;
			wait_drained();
			calm = ($urandom_range(0, 4) == 0);
			maybe_write(REG_WIDTH, with_junk(rand_dim(), DIM_W));
			maybe_write(REG_HEIGHT, with_junk(rand_dim(), DIM_W));
			maybe_write(REG_COEF_XX, with_junk(rand_coef(), COEF_W));
			maybe_write(REG_COEF_XY, with_junk(rand_coef(), COEF_W));
			maybe_write(REG_COEF_YX, with_junk(rand_coef(), COEF_W));
			maybe_write(REG_COEF_YY, with_junk(rand_coef(), COEF_W));
			maybe_write(REG_SHIFT_X, with_junk($urandom_range(0, 4095), COEF_W));
			maybe_write(REG_SHIFT_Y, with_junk($urandom_range(0, 4095), COEF_W));
			batch = $urandom_range(20, 120);
			inv_pct = $urandom_range(0, 100);
			for (int n = 0; n < batch; n++) begin
				send_pixel(($urandom_range(0, 99) < inv_pct) ? DIR_INV : DIR_FWD,
					$urandom, 1'b0, '0);
			end
			sent += batch;
		end

		pix.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
